>>> sv/tsui_pkg.sv
`timescale 1ns / 1ps

package tsui_pkg;

	// step_policy codes
	localparam logic [1:0] POL_FLAT     = 2'd0;
	localparam logic [1:0] POL_EXTEND   = 2'd1;
	localparam logic [1:0] POL_EXT_DOWN = 2'd2;

	// scan_axis codes
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_PASS = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SLOPE_LIM   = 2'd0;
	localparam logic [1:0] REG_STEP_POLICY = 2'd1;
	localparam logic [1:0] REG_SCAN_AXIS   = 2'd2;

	localparam int SLOPE_W    = 16;
	localparam int SLOPE_FRAC = 8;
	localparam logic [SLOPE_W-1:0] SLOPE_RST = 16'd2560; // 10.0 in Q8.8

	// run position
	localparam logic [1:0] RUN_START = 2'd0;
	localparam logic [1:0] RUN_ONE   = 2'd1;
	localparam logic [1:0] RUN_MANY  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROUTE,
		S_TEST,
		S_DECIDE,
		S_MUL,
		S_DIVL,
		S_DIV,
		S_FIN,
		S_EMIT_INS,
		S_EMIT_HELD,
		S_EMIT_NX
	} state_t;

	typedef enum logic [1:0] {
		EM_NX,
		EM_INS,
		EM_HELD
	} emit_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      take_first;  // held <= new point
		logic      shift_pts;   // before <= held, held <= new point
		logic      test;
		logic      insz_hold;   // inserted z from held point
		logic      mul_load;
		logic      mul_step;
		logic      div_load;
		logic      div_step;
		logic      insz_calc;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic daf_zero;
		logic nlast;
		logic out_free;
	} stat_t;

endpackage

>>> sv/tsui_ctrl.sv
`timescale 1ns / 1ps

module tsui_ctrl #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          step_policy,
	input  logic [1:0]          scan_axis,
	input  tsui_pkg::stat_t     stat,
	output tsui_pkg::cmd_t      cmd
);

	localparam int CW = $clog2(COORD_WIDTH + 1);

	tsui_pkg::state_t state_q, state_d;
	logic [1:0]       run_q, run_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             extend;
	logic             cnt_end;

	assign extend  = (step_policy == tsui_pkg::POL_EXTEND) ||
	                 (step_policy == tsui_pkg::POL_EXT_DOWN);
	assign cnt_end = (cnt_q == CW'(COORD_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsui_pkg::S_IDLE;
			run_q   <= tsui_pkg::RUN_START;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		run_d    = run_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.emit_sel = tsui_pkg::EM_NX;
		s_tready = 1'b0;
		unique case (state_q)
			tsui_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = tsui_pkg::S_ROUTE;
				end
			end
			tsui_pkg::S_ROUTE: begin
				if (run_q == tsui_pkg::RUN_START) begin
					state_d = tsui_pkg::S_EMIT_NX;
				end else if (run_q == tsui_pkg::RUN_ONE) begin
					if (stat.nlast) begin
						state_d = tsui_pkg::S_EMIT_NX;
					end else begin
						cmd.shift_pts = 1'b1;
						run_d         = tsui_pkg::RUN_MANY;
						state_d       = tsui_pkg::S_IDLE;
					end
				end else if (scan_axis[1]) begin
					state_d = tsui_pkg::S_EMIT_HELD;
				end else begin
					state_d = tsui_pkg::S_TEST;
				end
			end
			tsui_pkg::S_TEST: begin
				cmd.test = 1'b1;
				state_d  = tsui_pkg::S_DECIDE;
			end
			tsui_pkg::S_DECIDE: begin
				if (!stat.hit) begin
					state_d = tsui_pkg::S_EMIT_HELD;
				end else if (extend && !stat.daf_zero) begin
					cmd.mul_load = 1'b1;
					cnt_d        = '0;
					state_d      = tsui_pkg::S_MUL;
				end else begin
					cmd.insz_hold = 1'b1;
					state_d       = tsui_pkg::S_EMIT_INS;
				end
			end
			tsui_pkg::S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_end) state_d = tsui_pkg::S_DIVL;
			end
			tsui_pkg::S_DIVL: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = tsui_pkg::S_DIV;
			end
			tsui_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_end) state_d = tsui_pkg::S_FIN;
			end
			tsui_pkg::S_FIN: begin
				cmd.insz_calc = 1'b1;
				state_d       = tsui_pkg::S_EMIT_INS;
			end
			tsui_pkg::S_EMIT_INS: begin
				cmd.emit_sel = tsui_pkg::EM_INS;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tsui_pkg::S_EMIT_HELD;
				end
			end
			tsui_pkg::S_EMIT_HELD: begin
				cmd.emit_sel = tsui_pkg::EM_HELD;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.nlast) begin
						state_d = tsui_pkg::S_EMIT_NX;
					end else begin
						cmd.shift_pts = 1'b1;
						state_d       = tsui_pkg::S_IDLE;
					end
				end
			end
			tsui_pkg::S_EMIT_NX: begin
				cmd.emit_sel = tsui_pkg::EM_NX;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tsui_pkg::S_IDLE;
					if (run_q == tsui_pkg::RUN_START) begin
						cmd.take_first = 1'b1;
						run_d = stat.nlast ? tsui_pkg::RUN_START : tsui_pkg::RUN_ONE;
					end else begin
						cmd.shift_pts = (run_q != tsui_pkg::RUN_ONE);
						run_d         = tsui_pkg::RUN_START;
					end
				end
			end
			default: state_d = tsui_pkg::S_IDLE;
		endcase
	end

endmodule

>>> sv/tsui_dp.sv
`timescale 1ns / 1ps

module tsui_dp #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [COORD_WIDTH-1:0]     nx_x,
	input  logic signed [COORD_WIDTH-1:0]     nx_y,
	input  logic signed [COORD_WIDTH-1:0]     nx_z,
	input  logic                              nx_last,
	input  logic [tsui_pkg::SLOPE_W-1:0]      slope_lim,
	input  logic [1:0]                        step_policy,
	input  logic [1:0]                        scan_axis,
	input  tsui_pkg::cmd_t                    cmd,
	output tsui_pkg::stat_t                   stat,
	input  logic                              m_tready,
	output logic                              m_valid,
	output logic signed [COORD_WIDTH-1:0]     m_x,
	output logic signed [COORD_WIDTH-1:0]     m_y,
	output logic signed [COORD_WIDTH-1:0]     m_z,
	output logic                              m_last,
	output logic                              m_ins,
	output logic                              m_zs
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = 2 * W + 2;
	localparam int TW = W + 1 + tsui_pkg::SLOPE_W;
	localparam logic signed [W+1:0] ZMAX = $signed({3'b000, {(W-1){1'b1}}});
	localparam logic signed [W+1:0] ZMIN = $signed({3'b111, {(W-1){1'b0}}});

	logic signed [W-1:0] nx_x_q, nx_y_q, nx_z_q;
	logic                nx_last_q;
	logic signed [W-1:0] held_x_q, held_y_q, held_z_q;
	logic signed [W-1:0] bef_x_q, bef_y_q, bef_z_q;

	logic signed [W:0]   rise_q;
	logic [TW-1:0]       tprod_q;
	logic [W:0]          mcand_q, dvs_q, rem_q, quo_q;
	logic [PW-1:0]       prod_q;
	logic                neg_q, ovf_q;
	logic signed [W-1:0] insz_q;
	logic                zs_q;

	logic signed [W-1:0] ha, ba, na;
	logic signed [W:0]   d_travel, d_rise, d_dzf, d_dab, d_daf;
	logic [W:0]          travel, a_dzf, a_dab, a_daf;
	logic [W+1:0]        mul_sum, div_t, div_diff;
	logic                div_ge;
	logic [W:0]          cap, q;
	logic signed [W+1:0] dz, zsum;
	logic signed [W-1:0] zsat;
	logic [TW-1:0]       rise_sh;

	function automatic logic [W:0] mag(input logic signed [W:0] v);
		mag = v[W] ? (~v + 1'b1) : v;
	endfunction

	assign ha = scan_axis[0] ? held_y_q : held_x_q;
	assign ba = scan_axis[0] ? bef_y_q  : bef_x_q;
	assign na = scan_axis[0] ? nx_y_q   : nx_x_q;

	assign d_travel = (W+1)'(ha) - (W+1)'(ba);
	assign d_rise   = (W+1)'(held_z_q) - (W+1)'(bef_z_q);
	assign d_dzf    = (W+1)'(nx_z_q) - (W+1)'(held_z_q);
	assign d_dab    = (W+1)'(ba) - (W+1)'(ha);
	assign d_daf    = (W+1)'(na) - (W+1)'(ha);
	assign travel   = mag(d_travel);
	assign a_dzf    = mag(d_dzf);
	assign a_dab    = mag(d_dab);
	assign a_daf    = mag(d_daf);

	// rise * 256 > travel * slope limit, rise positive
	assign rise_sh  = TW'({rise_q[W-1:0], {tsui_pkg::SLOPE_FRAC{1'b0}}});
	assign stat.hit = !rise_q[W] && (rise_q != '0) && (rise_sh > tprod_q);
	assign stat.daf_zero = (na == ha);
	assign stat.nlast    = nx_last_q;
	assign stat.out_free = !m_valid || m_tready;

	// shift-add multiply, one multiplier bit per cycle
	assign mul_sum = {1'b0, prod_q[PW-1:W+1]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	// restoring divide, one quotient bit per cycle
	assign div_t    = {rem_q, quo_q[W]};
	assign div_ge   = div_t >= {1'b0, dvs_q};
	assign div_diff = div_t - {1'b0, dvs_q};

	// quotient capped at 2^W; anything that large saturates anyway
	assign cap  = {1'b1, {W{1'b0}}};
	assign q    = (ovf_q || quo_q > cap) ? cap : quo_q;
	assign dz   = (step_policy == tsui_pkg::POL_EXT_DOWN && !neg_q) ? '0 :
	              neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign zsum = (W+2)'(held_z_q) + dz;
	assign zsat = (zsum > ZMAX) ? ZMAX[W-1:0] :
	              (zsum < ZMIN) ? ZMIN[W-1:0] :
	              zsum[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			nx_x_q    <= nx_x;
			nx_y_q    <= nx_y;
			nx_z_q    <= nx_z;
			nx_last_q <= nx_last;
		end
		if (cmd.test) begin
			rise_q  <= d_rise;
			tprod_q <= TW'(travel) * TW'(slope_lim);
		end
		if (cmd.mul_load) begin
			mcand_q <= a_dzf;
			prod_q  <= PW'(a_dab);
			dvs_q   <= a_daf;
			neg_q   <= d_dzf[W] ^ d_dab[W] ^ d_daf[W];
		end else if (cmd.mul_step) begin
			prod_q  <= {mul_sum, prod_q[W:1]};
		end
		if (cmd.div_load) begin
			rem_q <= prod_q[PW-1:W+1];
			quo_q <= prod_q[W:0];
			ovf_q <= prod_q[PW-1:W+1] >= dvs_q;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[W:0] : div_t[W:0];
			quo_q <= {quo_q[W-1:0], div_ge};
		end
		if (cmd.insz_hold) begin
			insz_q <= held_z_q;
			zs_q   <= (step_policy == tsui_pkg::POL_EXTEND) ||
			          (step_policy == tsui_pkg::POL_EXT_DOWN);
		end else if (cmd.insz_calc) begin
			insz_q <= zsat;
			zs_q   <= 1'b0;
		end
		if (cmd.emit) begin
			case (cmd.emit_sel)
				tsui_pkg::EM_INS: begin
					m_x <= bef_x_q; m_y <= bef_y_q; m_z <= insz_q;
					m_last <= 1'b0; m_ins <= 1'b1; m_zs <= zs_q;
				end
				tsui_pkg::EM_HELD: begin
					m_x <= held_x_q; m_y <= held_y_q; m_z <= held_z_q;
					m_last <= 1'b0; m_ins <= 1'b0; m_zs <= 1'b0;
				end
				default: begin
					m_x <= nx_x_q; m_y <= nx_y_q; m_z <= nx_z_q;
					m_last <= nx_last_q; m_ins <= 1'b0; m_zs <= 1'b0;
				end
			endcase
		end
	end

	// point history resets to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0; held_y_q <= '0; held_z_q <= '0;
			bef_x_q  <= '0; bef_y_q  <= '0; bef_z_q  <= '0;
			m_valid  <= 1'b0;
		end else begin
			if (cmd.shift_pts) begin
				bef_x_q <= held_x_q; bef_y_q <= held_y_q; bef_z_q <= held_z_q;
			end
			if (cmd.shift_pts || cmd.take_first) begin
				held_x_q <= nx_x_q; held_y_q <= nx_y_q; held_z_q <= nx_z_q;
			end
			if (cmd.emit)        m_valid <= 1'b1;
			else if (m_tready)   m_valid <= 1'b0;
		end
	end

endmodule

>>> sv/toolpath_step_up_insertion.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata {z,y,x}, s_tlast run end
// m_*     | out | m_tvalid/m_tready  | m_tdata {z,y,x}, m_tlast, m_tuser flags
// cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// One word at a time: each word is accepted and then routed; a word tested on the
// scan axis also passes through test and decide, and each result word is emitted
// in turn. An extended insertion adds the multiplier, the divider load, the
// divider and the finish step before its result words.
// arst_n clears the point history, run position and config registers to defaults.
// A stalled m_tready only holds the emit states; the output register parts the sides.
module toolpath_step_up_insertion #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,  // in_x, in_y, in_z
	input  logic                                   s_tlast,  // in_last
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,  // out_x, out_y, out_z
	output logic                                   m_tlast,  // out_last
	output logic [7:0]                             m_tuser,  // is_inserted, zero_step
	input  logic                                   cfg_we,
	input  logic [1:0]                             cfg_index,
	input  logic [tsui_pkg::SLOPE_W-1:0]           cfg_data
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8;

	logic [tsui_pkg::SLOPE_W-1:0] slope_lim_q;
	logic [1:0]                   step_policy_q;
	logic [1:0]                   scan_axis_q;

	tsui_pkg::cmd_t  cmd;
	tsui_pkg::stat_t stat;

	logic signed [W-1:0] m_x, m_y, m_z;
	logic                m_ins, m_zs;

	// config registers; index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_lim_q   <= tsui_pkg::SLOPE_RST;
			step_policy_q <= tsui_pkg::POL_FLAT;
			scan_axis_q   <= tsui_pkg::AXIS_X;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsui_pkg::REG_SLOPE_LIM:   slope_lim_q   <= cfg_data;
				tsui_pkg::REG_STEP_POLICY: step_policy_q <= cfg_data[1:0];
				tsui_pkg::REG_SCAN_AXIS:   scan_axis_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	tsui_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.step_policy (step_policy_q),
		.scan_axis   (scan_axis_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	tsui_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.nx_x        (s_tdata[W-1:0]),
		.nx_y        (s_tdata[2*W-1:W]),
		.nx_z        (s_tdata[3*W-1:2*W]),
		.nx_last     (s_tlast),
		.slope_lim   (slope_lim_q),
		.step_policy (step_policy_q),
		.scan_axis   (scan_axis_q),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_tready),
		.m_valid     (m_tvalid),
		.m_x         (m_x),
		.m_y         (m_y),
		.m_z         (m_z),
		.m_last      (m_tlast),
		.m_ins       (m_ins),
		.m_zs        (m_zs)
	);

	assign m_tdata = DW'({m_z, m_y, m_x});
	assign m_tuser = {6'd0, m_zs, m_ins};

	// zero-step flag only ever rides on an inserted word
	a_zs_ins: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("zero_step without is_inserted");

	// an inserted word is never the end of a run
	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast)
		else $error("inserted word marked last");

	// input is only taken while no result word is being produced
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.emit)
		else $error("input ready during emission");

endmodule
